>>> hw/rtl/i2cms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master sequencer package
// Shared item and result types, bus commands, status codes and flag bits.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  typedef enum logic [1:0] {
    OP_BUF_WRITE = 2'd0,
    OP_BUF_READ  = 2'd1,
    OP_START     = 2'd2,
    OP_BUS_EVENT = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_SEND    = 3'd2,
    CMD_RX_ACK  = 3'd3,
    CMD_RX_NACK = 3'd4,
    CMD_STOP    = 3'd5
  } bus_cmd_e;

  // Controller status codes after masking with STATUS_MASK.
  localparam logic [7:0] STATUS_MASK     = 8'hF8;
  localparam logic [7:0] STAT_START      = 8'h08;
  localparam logic [7:0] STAT_RSTART     = 8'h10;
  localparam logic [7:0] STAT_ADDR_ACK   = 8'h18;
  localparam logic [7:0] STAT_TX_ACK     = 8'h28;
  localparam logic [7:0] STAT_RX_ACK     = 8'h50;

  // Bit positions in the status flag vector.
  localparam int unsigned FLAG_W    = 5;
  localparam int unsigned FL_ERR    = 0;
  localparam int unsigned FL_AACK   = 1;
  localparam int unsigned FL_AVAL   = 2;
  localparam int unsigned FL_DACK   = 3;
  localparam int unsigned FL_DVAL   = 4;

  typedef struct packed {
    opcode_e    opcode;
    logic [2:0] buffer_index;
    logic [7:0] buffer_byte;
    logic [7:0] slave_address;
    logic [2:0] byte_count;
    logic [7:0] direction_mask;
    logic [7:0] bus_status;
    logic [7:0] received_byte;
  } item_t;

  typedef struct packed {
    bus_cmd_e          bus_command;
    logic [7:0]        transmit_byte;
    logic [7:0]        read_byte;
    logic              busy;
    logic [FLAG_W-1:0] flags;
  } result_t;

endpackage

>>> hw/rtl/i2cms_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master sequencer core
// Holds the sequencer state and data buffer and decides one item per cycle in which fire_i is high.
// ----------------------------------------------------------------------------
module i2cms_core
  import i2cms_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = 8
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  item_t   item_i,
  output result_t res_o
);

  localparam int unsigned IdxW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam logic [3:0]  DepthLim = 4'(BUFFER_DEPTH);

  localparam logic [2:0] ST_READY  = 3'd0;
  localparam logic [2:0] ST_START  = 3'd1;
  localparam logic [2:0] ST_RSTART = 3'd2;
  localparam logic [2:0] ST_ADR    = 3'd3;
  localparam logic [2:0] ST_TX     = 3'd4;
  localparam logic [2:0] ST_RX     = 3'd5;
  localparam logic [2:0] ST_STOP   = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [2:0]        idx_q, idx_d;
  logic [2:0]        cnt_q, cnt_d;
  logic [7:0]        addr_q, addr_d;
  logic [7:0]        mask_q, mask_d;
  logic [FLAG_W-1:0] flags_q, flags_d;
  logic [7:0]        buf_q [BUFFER_DEPTH];

  logic [7:0] status;
  logic [2:0] idx_inc;
  logic [2:0] rd_addr;
  logic [7:0] rd_data;
  logic       wr_en;
  logic [2:0] wr_addr;
  logic [7:0] wr_data;
  logic       start_ok;

  assign status  = item_i.bus_status & STATUS_MASK;
  assign idx_inc = idx_q + 3'd1;

  // One buffer read a cycle: the software read index, entry zero after the
  // address phase, or the next data entry during a write burst.
  always_comb begin
    if (item_i.opcode == OP_BUF_READ) begin
      rd_addr = item_i.buffer_index;
    end else if (state_q == ST_ADR) begin
      rd_addr = 3'd0;
    end else begin
      rd_addr = idx_inc;
    end
  end

  assign rd_data = ({1'b0, rd_addr} < DepthLim) ? buf_q[rd_addr[IdxW-1:0]] : 8'h00;
  assign start_ok = ((state_q == ST_START) && (status == STAT_START)) ||
                    ((state_q == ST_RSTART) && (status == STAT_RSTART));

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    addr_d  = addr_q;
    mask_d  = mask_q;
    flags_d = flags_q;
    wr_en   = 1'b0;
    wr_addr = item_i.buffer_index;
    wr_data = item_i.buffer_byte;
    res_o.bus_command   = CMD_NONE;
    res_o.transmit_byte = 8'h00;
    res_o.read_byte     = 8'h00;

    unique case (item_i.opcode)
      OP_BUF_WRITE: begin
        wr_en = 1'b1;
      end
      OP_BUF_READ: begin
        res_o.read_byte = rd_data;
      end
      OP_START: begin
        if (item_i.byte_count != 3'd0) begin
          addr_d  = item_i.slave_address;
          cnt_d   = item_i.byte_count;
          mask_d  = item_i.direction_mask;
          flags_d = '0;
          idx_d   = 3'd0;
          state_d = ST_START;
          res_o.bus_command = CMD_START;
        end
      end
      OP_BUS_EVENT: begin
        unique case (state_q)
          ST_START, ST_RSTART: begin
            if (start_ok) begin
              res_o.bus_command   = CMD_SEND;
              res_o.transmit_byte = addr_q;
              state_d = ST_ADR;
            end else begin
              flags_d[FL_ERR] = 1'b1;
              state_d = ST_STOP;
            end
          end
          ST_ADR: begin
            flags_d[FL_AVAL] = 1'b1;
            if (status == STAT_ADDR_ACK) begin
              flags_d[FL_AACK] = 1'b1;
              if (mask_q[0]) begin
                res_o.bus_command   = CMD_SEND;
                res_o.transmit_byte = rd_data;
                state_d = ST_TX;
              end else begin
                // The first read byte lands in entry zero at the address event.
                wr_en   = 1'b1;
                wr_addr = 3'd0;
                wr_data = item_i.received_byte;
                res_o.bus_command = CMD_RX_NACK;
                state_d = ST_RX;
              end
            end else begin
              flags_d[FL_AACK] = 1'b0;
              state_d = ST_STOP;
            end
          end
          ST_TX: begin
            flags_d[FL_DVAL] = 1'b1;
            if (status == STAT_TX_ACK) begin
              idx_d = idx_inc;
              flags_d[FL_DACK] = 1'b1;
              if (idx_inc >= cnt_q) begin
                state_d = ST_STOP;
              end else if (mask_q[idx_inc]) begin
                res_o.bus_command   = CMD_SEND;
                res_o.transmit_byte = rd_data;
              end else begin
                res_o.bus_command = CMD_START;
                state_d = ST_RSTART;
              end
            end else begin
              flags_d[FL_DACK] = 1'b0;
              state_d = ST_STOP;
            end
          end
          ST_RX: begin
            flags_d[FL_DVAL] = 1'b1;
            if (status == STAT_RX_ACK) begin
              idx_d = idx_inc;
              flags_d[FL_DACK] = 1'b1;
              wr_en   = 1'b1;
              wr_addr = idx_inc;
              wr_data = item_i.received_byte;
              if (idx_inc >= cnt_q) begin
                res_o.bus_command = CMD_RX_NACK;
                state_d = ST_STOP;
              end else if (mask_q[idx_inc]) begin
                res_o.bus_command = CMD_RX_NACK;
                state_d = ST_RSTART;
              end else begin
                res_o.bus_command = CMD_RX_ACK;
              end
            end else begin
              flags_d[FL_DACK] = 1'b0;
              state_d = ST_STOP;
            end
          end
          default: begin
            // Ready, stop and unused codes all close the transaction.
            cnt_d   = 3'd0;
            state_d = ST_READY;
            res_o.bus_command = CMD_STOP;
          end
        endcase
      end
      default: begin
      end
    endcase

    res_o.busy  = (state_d != ST_READY);
    res_o.flags = flags_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_READY;
      idx_q   <= 3'd0;
      cnt_q   <= 3'd0;
      addr_q  <= 8'h00;
      mask_q  <= 8'h00;
      flags_q <= '0;
    end else if (fire_i) begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      addr_q  <= addr_d;
      mask_q  <= mask_d;
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && wr_en && ({1'b0, wr_addr} < DepthLim)) begin
      buf_q[wr_addr[IdxW-1:0]] <= wr_data;
    end
  end

  // A start with a nonzero count always enters the start state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (item_i.opcode == OP_START) && (item_i.byte_count != 3'd0)
    |=> (state_q == ST_START) && (idx_q == 3'd0))
    else $error("start request did not arm the sequencer");

  // While bytes move, the index stays below the byte count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TX) || (state_q == ST_RX) |-> (idx_q < cnt_q))
    else $error("data index ran past the byte count");

  // A bus event in the stop state returns to ready with the count cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (item_i.opcode == OP_BUS_EVENT) && (state_q == ST_STOP)
    |=> (state_q == ST_READY) && (cnt_q == 3'd0))
    else $error("stop event did not close the transaction");

endmodule

>>> hw/rtl/i2c_master_sequence_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master sequence engine
// Buffer access, transaction start and bus event sequencing in one channel.
// ----------------------------------------------------------------------------
// Usage:
// Each input transfer is one item: a buffer write, a buffer read, a start
// request or a bus status event from the controller. Every item produces
// exactly one output transfer carrying the next bus command, the byte to
// send, the buffer read data, the busy bit and the status flags.
// Both channels use valid and stall; a transfer happens on a clock edge with
// valid high and stall low.
// An accepted item waits in the input register, is decided there by the
// sequencer core, and is loaded into the output register, whose valid rises
// in the cycle after the item is decided; a stall on the output can hold the
// item in the input register. One item per cycle is sustained while the
// receiver does not stall, since the state and buffer update of one item
// completes in the cycle it is decided.
// When the receiver stalls, the output register holds its result and the
// input register still takes one more item; the input stalls only when both
// are full.
// Reset clears both valid bits, returns the sequencer to ready and clears
// the flags, index, count, address and mask. The data buffer is not cleared;
// an entry reads back undefined until software writes it.
// ----------------------------------------------------------------------------
module i2c_master_sequence_engine_unit
  import i2cms_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,

  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] opcode_i,
  input  logic [2:0] buffer_index_i,
  input  logic [7:0] buffer_byte_i,
  input  logic [7:0] slave_address_i,
  input  logic [2:0] byte_count_i,
  input  logic [7:0] direction_mask_i,
  input  logic [7:0] bus_status_i,
  input  logic [7:0] received_byte_i,

  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] bus_command_o,
  output logic [7:0] transmit_byte_o,
  output logic [7:0] read_byte_o,
  output logic       busy_res_o,
  output logic       start_error_o,
  output logic       address_ack_o,
  output logic       address_ack_valid_o,
  output logic       data_ack_o,
  output logic       data_ack_valid_o
);

  logic    in_valid_q, in_valid_d;
  logic    out_valid_q, out_valid_d;
  item_t   item_q;
  result_t res_q;
  result_t res;
  logic    out_ready;
  logic    in_accept;
  logic    fire;

  // The output register can load when it is empty or being drained.
  assign out_ready  = !out_valid_q || !out_stall_i;
  // An item is decided, and the sequencer state updated, as it moves on.
  assign fire       = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign in_valid_d  = in_accept || (in_valid_q && !fire);
  assign out_valid_d = fire || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.opcode         <= opcode_e'(opcode_i);
      item_q.buffer_index   <= buffer_index_i;
      item_q.buffer_byte    <= buffer_byte_i;
      item_q.slave_address  <= slave_address_i;
      item_q.byte_count     <= byte_count_i;
      item_q.direction_mask <= direction_mask_i;
      item_q.bus_status     <= bus_status_i;
      item_q.received_byte  <= received_byte_i;
    end
    if (fire) begin
      res_q <= res;
    end
  end

  i2cms_core #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item_q),
    .res_o  (res)
  );

  assign out_valid_o         = out_valid_q;
  assign bus_command_o       = res_q.bus_command;
  assign transmit_byte_o     = res_q.transmit_byte;
  assign read_byte_o         = res_q.read_byte;
  assign busy_res_o          = res_q.busy;
  assign start_error_o       = res_q.flags[FL_ERR];
  assign address_ack_o       = res_q.flags[FL_AACK];
  assign address_ack_valid_o = res_q.flags[FL_AVAL];
  assign data_ack_o          = res_q.flags[FL_DACK];
  assign data_ack_valid_o    = res_q.flags[FL_DVAL];

  // A new result only appears when the input register held an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_valid_q))
    else $error("result appeared without a pending item");

  // A stalled full output with a pending item must hold off the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && out_stall_i |=> in_valid_q && out_valid_q)
    else $error("pending item or result was dropped under stall");

  // An acknowledged address is always marked valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.flags[FL_AACK] |-> res_q.flags[FL_AVAL])
    else $error("address ack flag set without its valid flag");

endmodule

>>> sim/i2cms_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master sequencer result checker
// Watches both channels, predicts one result per accepted item and compares
// each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module i2cms_result_checker
  import i2cms_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  opcode_i,
  input  logic [2:0]  buffer_index_i,
  input  logic [7:0]  buffer_byte_i,
  input  logic [7:0]  slave_address_i,
  input  logic [2:0]  byte_count_i,
  input  logic [7:0]  direction_mask_i,
  input  logic [7:0]  bus_status_i,
  input  logic [7:0]  received_byte_i,

  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  bus_command_i,
  input  logic [7:0]  transmit_byte_i,
  input  logic [7:0]  read_byte_i,
  input  logic        busy_res_i,
  input  logic        start_error_i,
  input  logic        address_ack_i,
  input  logic        address_ack_valid_i,
  input  logic        data_ack_i,
  input  logic        data_ack_valid_i,

  output int unsigned fail_count_o,
  output int unsigned results_waiting_o,
  output int unsigned results_checked_o
);

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_START_SENT,
    SEQ_RESTART_SENT,
    SEQ_ADDR_SENT,
    SEQ_DATA_SENT,
    SEQ_DATA_RCVD,
    SEQ_STOP
  } seq_state_e;

  // Shadow of the sequencer.
  seq_state_e        seq;
  logic [7:0]        byte_store [8];
  logic [2:0]        byte_pos;
  logic [2:0]        bytes_left;
  logic [7:0]        addr_byte;
  logic [7:0]        dir_bits;
  logic [FLAG_W-1:0] flag_bits;

  result_t     expected_results [$];
  result_t     got;
  result_t     want;
  item_t       incoming;
  int unsigned fails;
  int unsigned checked;

  function automatic result_t predict_response(input item_t it);
    result_t    r;
    logic [7:0] status;
    r.bus_command   = CMD_NONE;
    r.transmit_byte = '0;
    r.read_byte     = '0;
    r.busy          = 1'b0;
    r.flags         = '0;
    status = it.bus_status & STATUS_MASK;
    case (it.opcode)
      OP_BUF_WRITE: begin
        if (it.buffer_index < BUFFER_DEPTH) byte_store[it.buffer_index] = it.buffer_byte;
      end
      OP_BUF_READ: begin
        if (it.buffer_index < BUFFER_DEPTH) r.read_byte = byte_store[it.buffer_index];
      end
      OP_START: begin
        // A start with a count is taken in any state, busy or not.
        if (it.byte_count != 3'd0) begin
          addr_byte     = it.slave_address;
          bytes_left    = it.byte_count;
          dir_bits      = it.direction_mask;
          flag_bits     = '0;
          byte_pos      = '0;
          r.bus_command = CMD_START;
          seq           = SEQ_START_SENT;
        end
      end
      default: begin
        case (seq)
          SEQ_START_SENT, SEQ_RESTART_SENT: begin
            if ((seq == SEQ_START_SENT && status == STAT_START) ||
                (seq == SEQ_RESTART_SENT && status == STAT_RSTART)) begin
              r.bus_command   = CMD_SEND;
              r.transmit_byte = addr_byte;
              seq             = SEQ_ADDR_SENT;
            end else begin
              flag_bits[FL_ERR] = 1'b1;
              seq               = SEQ_STOP;
            end
          end
          SEQ_ADDR_SENT: begin
            if (status == STAT_ADDR_ACK) begin
              flag_bits[FL_AACK] = 1'b1;
              flag_bits[FL_AVAL] = 1'b1;
              // Direction after the address always follows bit 0 of the mask.
              if (dir_bits[0]) begin
                r.bus_command   = CMD_SEND;
                r.transmit_byte = byte_store[0];
                seq             = SEQ_DATA_SENT;
              end else begin
                byte_store[0] = it.received_byte;
                r.bus_command = CMD_RX_NACK;
                seq           = SEQ_DATA_RCVD;
              end
            end else begin
              flag_bits[FL_AACK] = 1'b0;
              flag_bits[FL_AVAL] = 1'b1;
              seq                = SEQ_STOP;
            end
          end
          SEQ_DATA_SENT: begin
            if (status == STAT_TX_ACK) begin
              byte_pos           = byte_pos + 3'd1;
              flag_bits[FL_DACK] = 1'b1;
              flag_bits[FL_DVAL] = 1'b1;
              if (byte_pos >= bytes_left) begin
                seq = SEQ_STOP;
              end else if (dir_bits[byte_pos]) begin
                r.bus_command = CMD_SEND;
                if (byte_pos < BUFFER_DEPTH) r.transmit_byte = byte_store[byte_pos];
                seq = SEQ_DATA_SENT;
              end else begin
                r.bus_command = CMD_START;
                seq           = SEQ_RESTART_SENT;
              end
            end else begin
              flag_bits[FL_DACK] = 1'b0;
              flag_bits[FL_DVAL] = 1'b1;
              seq                = SEQ_STOP;
            end
          end
          SEQ_DATA_RCVD: begin
            if (status == STAT_RX_ACK) begin
              byte_pos           = byte_pos + 3'd1;
              flag_bits[FL_DACK] = 1'b1;
              flag_bits[FL_DVAL] = 1'b1;
              if (byte_pos < BUFFER_DEPTH) byte_store[byte_pos] = it.received_byte;
              if (byte_pos >= bytes_left) begin
                r.bus_command = CMD_RX_NACK;
                seq           = SEQ_STOP;
              end else if (dir_bits[byte_pos]) begin
                r.bus_command = CMD_RX_NACK;
                seq           = SEQ_RESTART_SENT;
              end else begin
                r.bus_command = CMD_RX_ACK;
                seq           = SEQ_DATA_RCVD;
              end
            end else begin
              flag_bits[FL_DACK] = 1'b0;
              flag_bits[FL_DVAL] = 1'b1;
              seq                = SEQ_STOP;
            end
          end
          default: begin
            // Stop state, and an event while idle, both issue the stop.
            bytes_left    = '0;
            r.bus_command = CMD_STOP;
            seq           = SEQ_IDLE;
          end
        endcase
      end
    endcase
    r.busy  = (seq != SEQ_IDLE);
    r.flags = flag_bits;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq        = SEQ_IDLE;
      byte_pos   = '0;
      bytes_left = '0;
      addr_byte  = '0;
      dir_bits   = '0;
      flag_bits  = '0;
      for (int i = 0; i < 8; i++) byte_store[i] = '0;
      expected_results.delete();
      fails   = 0;
      checked = 0;
      fail_count_o      <= 0;
      results_waiting_o <= 0;
      results_checked_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got.bus_command        = bus_cmd_e'(bus_command_i);
        got.transmit_byte      = transmit_byte_i;
        got.read_byte          = read_byte_i;
        got.busy               = busy_res_i;
        got.flags[FL_ERR]      = start_error_i;
        got.flags[FL_AACK]     = address_ack_i;
        got.flags[FL_AVAL]     = address_ack_valid_i;
        got.flags[FL_DACK]     = data_ack_i;
        got.flags[FL_DVAL]     = data_ack_valid_i;
        if (expected_results.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: result transfer with nothing expected: cmd %0d tx %h rd %h",
                     $realtime, got.bus_command, got.transmit_byte, got.read_byte);
        end else begin
          want = expected_results.pop_front();
          checked++;
          if (got.bus_command !== want.bus_command || got.transmit_byte !== want.transmit_byte ||
              got.read_byte !== want.read_byte || got.busy !== want.busy ||
              got.flags !== want.flags) begin
            fails++;
            if (fails <= 10)
              $display({"%0t: result %0d mismatch (expected/actual): cmd %0d/%0d tx %h/%h ",
                        "rd %h/%h busy %b/%b flags %b/%b"}, $realtime, checked,
                       want.bus_command, got.bus_command, want.transmit_byte,
                       got.transmit_byte, want.read_byte, got.read_byte, want.busy,
                       got.busy, want.flags, got.flags);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        incoming.opcode         = opcode_e'(opcode_i);
        incoming.buffer_index   = buffer_index_i;
        incoming.buffer_byte    = buffer_byte_i;
        incoming.slave_address  = slave_address_i;
        incoming.byte_count     = byte_count_i;
        incoming.direction_mask = direction_mask_i;
        incoming.bus_status     = bus_status_i;
        incoming.received_byte  = received_byte_i;
        expected_results.push_back(predict_response(incoming));
      end
      fail_count_o      <= fails;
      results_waiting_o <= expected_results.size();
      results_checked_o <= checked;
    end
  end

endmodule

>>> sim/i2c_master_sequence_engine_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master sequence engine testbench
// Drives buffer accesses, start requests and scripted bus status events
// through the input channel under several idling patterns, while a checker
// beside the block predicts and compares every result transfer.
// ----------------------------------------------------------------------------
module i2c_master_sequence_engine_unit_tb;
  import i2cms_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 10;
  localparam int PHASE_ITEMS  = 160;
  localparam int HOLD_CYCLES  = 60;
  localparam int HOLD_ITEMS   = 30;
  // The tail leaves room for a stray result to show up after the last expected one.
  localparam int TAIL_CYCLES  = 8;
  localparam int TIMEOUT_NS   = 4_000_000;

  // Idling patterns for the sender and the receiver.
  typedef enum logic [2:0] {
    PH_FREE,
    PH_PRESSURE,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_BOTH
  } idle_phase_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  opcode_i;
  logic [2:0]  buffer_index_i;
  logic [7:0]  buffer_byte_i;
  logic [7:0]  slave_address_i;
  logic [2:0]  byte_count_i;
  logic [7:0]  direction_mask_i;
  logic [7:0]  bus_status_i;
  logic [7:0]  received_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  bus_command_o;
  logic [7:0]  transmit_byte_o;
  logic [7:0]  read_byte_o;
  logic        busy_res_o;
  logic        start_error_o;
  logic        address_ack_o;
  logic        address_ack_valid_o;
  logic        data_ack_o;
  logic        data_ack_valid_o;

  int unsigned fail_count;
  int unsigned results_waiting;
  int unsigned results_checked;

  idle_phase_e phase = PH_FREE;
  int          items_sent;
  int          transactions_run;
  int          hold_count;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  i2c_master_sequence_engine_unit dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .opcode_i            (opcode_i),
    .buffer_index_i      (buffer_index_i),
    .buffer_byte_i       (buffer_byte_i),
    .slave_address_i     (slave_address_i),
    .byte_count_i        (byte_count_i),
    .direction_mask_i    (direction_mask_i),
    .bus_status_i        (bus_status_i),
    .received_byte_i     (received_byte_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .bus_command_o       (bus_command_o),
    .transmit_byte_o     (transmit_byte_o),
    .read_byte_o         (read_byte_o),
    .busy_res_o          (busy_res_o),
    .start_error_o       (start_error_o),
    .address_ack_o       (address_ack_o),
    .address_ack_valid_o (address_ack_valid_o),
    .data_ack_o          (data_ack_o),
    .data_ack_valid_o    (data_ack_valid_o)
  );

  i2cms_result_checker result_check (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_i          (in_stall_o),
    .opcode_i            (opcode_i),
    .buffer_index_i      (buffer_index_i),
    .buffer_byte_i       (buffer_byte_i),
    .slave_address_i     (slave_address_i),
    .byte_count_i        (byte_count_i),
    .direction_mask_i    (direction_mask_i),
    .bus_status_i        (bus_status_i),
    .received_byte_i     (received_byte_i),
    .out_valid_i         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .bus_command_i       (bus_command_o),
    .transmit_byte_i     (transmit_byte_o),
    .read_byte_i         (read_byte_o),
    .busy_res_i          (busy_res_o),
    .start_error_i       (start_error_o),
    .address_ack_i       (address_ack_o),
    .address_ack_valid_i (address_ack_valid_o),
    .data_ack_i          (data_ack_o),
    .data_ack_valid_i    (data_ack_valid_o),
    .fail_count_o        (fail_count),
    .results_waiting_o   (results_waiting),
    .results_checked_o   (results_checked)
  );

  // Percentage of cycles in which one side sits idle under a given pattern.
  function automatic int unsigned stall_pct(input idle_phase_e ph, input bit receiver);
    case (ph)
      PH_SEND_IDLE:  return receiver ? 0 : 86;
      PH_RECV_STALL: return receiver ? 86 : 0;
      PH_BOTH:       return 22;
      default:       return 0;
    endcase
  endfunction

  // Every field gets a random value, so that bits that the opcode does not
  // use still toggle; callers override the fields that matter.
  function automatic item_t random_item();
    item_t it;
    it.opcode         = opcode_e'($urandom_range(0, 3));
    it.buffer_index   = 3'($urandom);
    it.buffer_byte    = 8'($urandom);
    it.slave_address  = 8'($urandom);
    it.byte_count     = 3'($urandom);
    it.direction_mask = 8'($urandom);
    it.bus_status     = 8'($urandom);
    it.received_byte  = 8'($urandom);
    return it;
  endfunction

  // Offers one item and returns once its transfer has taken place. Valid
  // stays high afterwards; the next call either lowers it for a gap or puts
  // the next item straight on the channel in the same step.
  task automatic send_item(input item_t it);
    while ($urandom_range(0, 99) < stall_pct(phase, 1'b0)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    opcode_i         <= it.opcode;
    buffer_index_i   <= it.buffer_index;
    buffer_byte_i    <= it.buffer_byte;
    slave_address_i  <= it.slave_address;
    byte_count_i     <= it.byte_count;
    direction_mask_i <= it.direction_mask;
    bus_status_i     <= it.bus_status;
    received_byte_i  <= it.received_byte;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_event(input logic [7:0] status);
    item_t it;
    it            = random_item();
    it.opcode     = OP_BUS_EVENT;
    it.bus_status = status;
    send_item(it);
  endtask

  // Waits until every predicted result has been taken. The checker updates
  // its count at the clock edge, so the first look comes after the next edge.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_waiting != 0) @(posedge clk_i);
  endtask

  // Runs one transaction: a start request followed by the status codes that
  // a well-behaved controller and slave would report. The script walks the
  // direction mask the way the sequencer does: a change of direction costs a
  // repeated start and a new address phase, and after that address phase
  // the direction comes from bit 0 of the mask again, not from the current
  // byte. fault_at puts a wrong status in place of that script entry and
  // ends with the stop event; abort_at drops the rest of the script so that
  // the next start request lands on a busy sequencer.
  task automatic run_transaction(input logic [2:0] cnt, input logic [7:0] mask,
                                 input logic [7:0] addr, input int fault_at,
                                 input int abort_at, input bit interleave);
    logic [7:0] codes [$];
    logic [7:0] bad;
    item_t      it;
    int         pos;
    bit         writing;
    codes.push_back(STAT_START);
    codes.push_back(STAT_ADDR_ACK);
    writing = mask[0];
    pos     = 0;
    while (pos < cnt) begin
      codes.push_back(writing ? STAT_TX_ACK : STAT_RX_ACK);
      pos++;
      if (pos < cnt && mask[pos] != writing) begin
        codes.push_back(STAT_RSTART);
        codes.push_back(STAT_ADDR_ACK);
        writing = mask[0];
      end
    end

    it                = random_item();
    it.opcode         = OP_START;
    it.byte_count     = cnt;
    it.direction_mask = mask;
    it.slave_address  = addr;
    send_item(it);
    transactions_run++;

    for (int k = 0; k < codes.size(); k++) begin
      if (k == abort_at) return;
      // Buffer traffic between bus events must not disturb the sequence.
      if (interleave && $urandom_range(0, 99) < 12) begin
        it        = random_item();
        it.opcode = $urandom_range(0, 1) ? OP_BUF_WRITE : OP_BUF_READ;
        send_item(it);
      end
      if (k == fault_at) begin
        do bad = 8'($urandom); while ((bad & STATUS_MASK) == codes[k]);
        send_event(bad);
        break;
      end
      // The low three status bits are masked off inside the block.
      send_event(codes[k] | 8'($urandom_range(0, 7)));
    end
    if (abort_at != codes.size()) send_event(8'($urandom));
  endtask

  // Mostly well-formed transactions with random content, the rest single
  // random items; ends with a drain so the sender pauses between patterns.
  task automatic run_phase(input idle_phase_e ph, input int n);
    int target;
    int fault_at;
    int abort_at;
    phase  <= ph;
    target = items_sent + n;
    while (items_sent < target) begin
      if ($urandom_range(0, 99) < 70) begin
        fault_at = ($urandom_range(0, 99) < 15) ? int'($urandom_range(0, 5)) : -1;
        abort_at = ($urandom_range(0, 99) < 8) ? int'($urandom_range(1, 9)) : -1;
        run_transaction(3'($urandom_range(1, 7)), 8'($urandom), 8'($urandom),
                        fault_at, abort_at, 1'b1);
      end else begin
        send_item(random_item());
      end
    end
    drain();
  endtask

  // Receiver side. Under the pressure pattern it holds stall high for a long
  // stretch, counted here, so that the output register and the input
  // register both fill and the block stalls the sender.
  initial begin
    out_stall_i = 1'b0;
    hold_count  = 0;
    forever begin
      @(posedge clk_i);
      if (phase == PH_PRESSURE && hold_count < HOLD_CYCLES) begin
        out_stall_i <= 1'b1;
        hold_count++;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < stall_pct(phase, 1'b1));
      end
    end
  end

  initial begin
    item_t it;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    opcode_i         = '0;
    buffer_index_i   = '0;
    buffer_byte_i    = '0;
    slave_address_i  = '0;
    byte_count_i     = '0;
    direction_mask_i = '0;
    bus_status_i     = '0;
    received_byte_i  = '0;
    items_sent       = 0;
    transactions_run = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The buffer comes out of reset undefined, so every entry is written
    // before anything can read it back, by software or by a send.
    for (int i = 0; i < 8; i++) begin
      it              = random_item();
      it.opcode       = OP_BUF_WRITE;
      it.buffer_index = 3'(i);
      it.buffer_byte  = (i == 0) ? 8'h00 : (i == 7) ? 8'hFF : 8'($urandom);
      send_item(it);
    end
    it              = random_item();
    it.opcode       = OP_BUF_READ;
    it.buffer_index = 3'd7;
    send_item(it);
    // A start with a zero count is ignored.
    it            = random_item();
    it.opcode     = OP_START;
    it.byte_count = 3'd0;
    send_item(it);
    // A bus event while ready answers with a stop.
    send_event(8'($urandom));
    // Single written byte: after its ack the command is none, then stop.
    run_transaction(3'd1, 8'hFF, 8'hFF, -1, -1, 1'b0);
    // Read path: first byte received at the address event, a change to
    // writing after a received byte, and the repeated start that follows.
    run_transaction(3'd3, 8'h02, 8'h00, -1, -1, 1'b0);
    // Left busy after the address ack; the next start restarts it and then
    // meets a wrong start status.
    run_transaction(3'd2, 8'hFF, 8'h5A, -1, 2, 1'b0);
    run_transaction(3'd7, 8'h00, 8'hA5, 0, -1, 1'b0);
    drain();

    run_phase(PH_FREE, PHASE_ITEMS);

    // Sender keeps offering items back to back while the receiver holds off.
    phase <= PH_PRESSURE;
    repeat (HOLD_ITEMS) send_item(random_item());
    drain();

    run_phase(PH_SEND_IDLE, PHASE_ITEMS);
    run_phase(PH_RECV_STALL, PHASE_ITEMS);
    run_phase(PH_BOTH, PHASE_ITEMS);

    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d item transfers, including %0d scripted transactions,",
             items_sent, transactions_run);
    $display("and %0d result transfers checked across five idling patterns.",
             results_checked);
    if (fail_count == 0 && results_waiting == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
